// ===== hdl/circle_pair_collision_resolver_core_macros.svh =====
// Assertion macros for the collision resolver core.
`ifndef CIRCLE_PAIR_COLLISION_RESOLVER_CORE_MACROS_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge out of reset.
`define CPCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define CPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPCR_ASSERT(lbl, prop, msg)
`define CPCR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/cpcr_pkg.sv =====
`default_nettype none

package cpcr_pkg;

    localparam int WORD_W  = 16;
    localparam int RAD_W   = 12;
    localparam int DIFF_W  = 17;             // difference/sum of two words
    localparam int RSUM_W  = 13;             // radius sum
    localparam int SQD_W   = 34;             // one squared difference
    localparam int D2_W    = 35;             // full squared distance
    localparam int SS_W    = 26;             // squared radius sum
    localparam int D2L_W   = 26;             // squared distance when overlapping
    localparam int NRM_W   = 14;             // |dx| < 2^13 when overlapping
    localparam int DOTP_W  = 31;
    localparam int DOT_W   = 32;
    localparam int PR_W    = 26;             // radius * normal component
    localparam int DEN_W   = 39;             // d2 * s
    localparam int VP_W    = 58;             // dot * radius * normal
    localparam int MX_W    = 39;             // centre sum * D
    localparam int PN_W    = 40;             // position numerator
    localparam int PSH     = 9;              // 512 scale of radius term
    localparam int SQ_IN_W = 42;
    localparam int SQ_W    = 21;
    localparam int SQ_SH   = SQ_IN_W - D2L_W;
    localparam int DIV_NW  = 58;
    localparam int DIV_DW  = 40;
    localparam int DIV_QW  = 19;
    localparam int DIV_RW  = DIV_DW + DIV_QW;
    localparam int SQ_W_EX = SQ_IN_W + 2;
    localparam int QS_W    = DIV_QW + 2;     // signed quotient / final sum

    // pipeline stage numbers
    localparam int K_SQ_IN  = 4;
    localparam int K_VEL    = 5;
    localparam int K_SQ_OUT = K_SQ_IN + SQ_W - 1;      // 24
    localparam int K_VQ     = K_VEL + DIV_QW + 1;      // 25, quotient in line
    localparam int K_P      = K_SQ_OUT + 1;            // 25
    localparam int K_PSG    = K_P + 2;                 // 27
    localparam int K_END    = K_PSG + DIV_QW;          // 46

    localparam int NLANE = 4;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [RAD_W-1:0]         t_rad;

    typedef struct packed {
        logic  hit;
        logic  zero;
        t_word ax;
        t_word ay;
        t_word avx;
        t_word avy;
        t_word bx;
        t_word by;
        t_word bvx;
        t_word bvy;
    } t_side;

    typedef struct packed {
        logic signed [DIFF_W-1:0] sumx;
        logic signed [DIFF_W-1:0] sumy;
        logic signed [PR_W-1:0]   pax;
        logic signed [PR_W-1:0]   pay;
        logic signed [PR_W-1:0]   pbx;
        logic signed [PR_W-1:0]   pby;
    } t_posing;

    typedef struct packed {
        logic [NLANE-1:0]             vsg;
        logic [NLANE-1:0]             psg;
        logic [NLANE-1:0][DIV_QW-1:0] vq;
    } t_vel;

    typedef struct packed {
        logic  hit;
        t_word nax;
        t_word nay;
        t_word navx;
        t_word navy;
        t_word nbx;
        t_word nby;
        t_word nbvx;
        t_word nbvy;
    } t_result;

    function automatic t_word sat16(input logic signed [QS_W-1:0] v);
        t_word r;
        if (v > QS_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -QS_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [QS_W-1:0] apply_sign(input logic sg,
                                                          input logic [DIV_QW-1:0] q);
        logic signed [QS_W-1:0] m;
        m = $signed({2'b00, q});
        return sg ? -m : m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/circle_pair_collision_resolver_core.sv =====
// Two-circle elastic collision resolver. Each input beat carries two circles
// (Q12.4 centre, Q8.8 velocity, Q8.4 radius, mass = radius); each output beat
// carries the hit flag and the resolved centres and velocities, saturated to
// 16 bits. Non-overlapping pairs, and overlapping pairs with coincident
// centres, come out with their input values. The core is a fully pipelined
// datapath: it takes one pair per clock while o_stall is low; a pair loads
// stage 1 on the accepting edge and passes through stages 1 to 46, then the
// output register. The pipeline depth is set by the 21-stage square root for
// the centre distance followed by the 19-stage divider for the position
// update; the velocity divides run in parallel with the square root. Results
// leave through an output register backed by one skid entry, so a pair is
// still taken while a result waits; o_stall rises only when both entries are
// full, and then the whole pipeline holds in place. No configuration, no state
// between pairs.
`default_nettype none

module circle_pair_collision_resolver_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  cpcr_pkg::t_word     i_a_x,
    input  cpcr_pkg::t_word     i_a_y,
    input  cpcr_pkg::t_word     i_a_vx,
    input  cpcr_pkg::t_word     i_a_vy,
    input  cpcr_pkg::t_rad      i_a_radius,
    input  cpcr_pkg::t_word     i_b_x,
    input  cpcr_pkg::t_word     i_b_y,
    input  cpcr_pkg::t_word     i_b_vx,
    input  cpcr_pkg::t_word     i_b_vy,
    input  cpcr_pkg::t_rad      i_b_radius,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output cpcr_pkg::t_word     o_new_a_x,
    output cpcr_pkg::t_word     o_new_a_y,
    output cpcr_pkg::t_word     o_new_a_vx,
    output cpcr_pkg::t_word     o_new_a_vy,
    output cpcr_pkg::t_word     o_new_b_x,
    output cpcr_pkg::t_word     o_new_b_y,
    output cpcr_pkg::t_word     o_new_b_vx,
    output cpcr_pkg::t_word     o_new_b_vy
);
    import cpcr_pkg::*;

    // ---------------------------------------------------------------
    // Pipeline enable: the pipe moves unless the skid entry is full.
    // ---------------------------------------------------------------
    logic    en;
    logic    r_ov;      // output register holds a beat
    logic    r_sv;      // skid entry holds a beat
    t_result r_o;
    t_result r_s;

    assign en      = !r_sv;
    assign o_stall = r_sv;

    // valid bit per stage
    logic [K_END:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[K_END-1:1], i_valid};
        end
    end

    // ---------------------------------------------------------------
    // Side line: original fields plus hit/zero flags (set at stage 3)
    // ---------------------------------------------------------------
    t_side r_la [1:K_END];
    t_side n_la3;
    logic  n_hit;
    logic  n_zero;

    always_comb begin
        n_la3      = r_la[2];
        n_la3.hit  = n_hit;
        n_la3.zero = n_zero;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_la[1] <= '{hit: 1'b0, zero: 1'b0,
                         ax: i_a_x, ay: i_a_y, avx: i_a_vx, avy: i_a_vy,
                         bx: i_b_x, by: i_b_y, bvx: i_b_vx, bvy: i_b_vy};
            for (int i = 2; i <= K_END; i++) begin
                r_la[i] <= (i == 3) ? n_la3 : r_la[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: differences and sums
    // ---------------------------------------------------------------
    logic signed [DIFF_W-1:0] r1_dx, r1_dy, r1_sumx, r1_sumy, r1_dvx, r1_dvy;
    logic [RSUM_W-1:0]        r1_s;
    t_rad                     r1_ar, r1_br;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx   <= DIFF_W'(i_a_x) - DIFF_W'(i_b_x);
            r1_dy   <= DIFF_W'(i_a_y) - DIFF_W'(i_b_y);
            r1_sumx <= DIFF_W'(i_a_x) + DIFF_W'(i_b_x);
            r1_sumy <= DIFF_W'(i_a_y) + DIFF_W'(i_b_y);
            r1_dvx  <= DIFF_W'(i_a_vx) - DIFF_W'(i_b_vx);
            r1_dvy  <= DIFF_W'(i_a_vy) - DIFF_W'(i_b_vy);
            r1_s    <= RSUM_W'(i_a_radius) + RSUM_W'(i_b_radius);
            r1_ar   <= i_a_radius;
            r1_br   <= i_b_radius;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: products. The normal is cut to 14 bits; that is exact
    // whenever the circles overlap, and unused otherwise.
    // ---------------------------------------------------------------
    logic signed [NRM_W-1:0]  dx14, dy14;
    logic signed [RAD_W:0]    ar_s, br_s;
    logic [SQD_W-1:0]         r2_dxx, r2_dyy;
    logic [SS_W-1:0]          r2_ss;
    logic signed [DOTP_W-1:0] r2_dotx, r2_doty;
    logic signed [PR_W-1:0]   r2_pax, r2_pay, r2_pbx, r2_pby;
    logic [RSUM_W-1:0]        r2_s;
    logic signed [DIFF_W-1:0] r2_sumx, r2_sumy;

    assign dx14 = r1_dx[NRM_W-1:0];
    assign dy14 = r1_dy[NRM_W-1:0];
    assign ar_s = $signed({1'b0, r1_ar});
    assign br_s = $signed({1'b0, r1_br});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dxx  <= SQD_W'(r1_dx * r1_dx);
            r2_dyy  <= SQD_W'(r1_dy * r1_dy);
            r2_ss   <= r1_s * r1_s;
            r2_dotx <= DOTP_W'(r1_dvx * dx14);
            r2_doty <= DOTP_W'(r1_dvy * dy14);
            r2_pax  <= PR_W'(ar_s * dx14);
            r2_pay  <= PR_W'(ar_s * dy14);
            r2_pbx  <= PR_W'(br_s * dx14);
            r2_pby  <= PR_W'(br_s * dy14);
            r2_s    <= r1_s;
            r2_sumx <= r1_sumx;
            r2_sumy <= r1_sumy;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: squared distance, overlap test, relative-velocity dot
    // ---------------------------------------------------------------
    logic [D2_W-1:0]          d2_full;
    logic [D2L_W-1:0]         r3_d2;
    logic signed [DOT_W-1:0]  r3_dot;
    logic [RSUM_W-1:0]        r3_s;
    t_posing                  r3_pi;

    assign d2_full = D2_W'(r2_dxx) + D2_W'(r2_dyy);
    assign n_hit   = d2_full < D2_W'(r2_ss);
    assign n_zero  = d2_full == '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d2  <= d2_full[D2L_W-1:0];
            r3_dot <= DOT_W'(r2_dotx) + DOT_W'(r2_doty);
            r3_s   <= r2_s;
            r3_pi  <= '{sumx: r2_sumx, sumy: r2_sumy,
                        pax: r2_pax, pay: r2_pay, pbx: r2_pbx, pby: r2_pby};
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: velocity numerators and denominator; square root starts
    // ---------------------------------------------------------------
    logic [DEN_W-1:0]        r4_den;
    logic signed [VP_W-1:0]  r4_vp [NLANE];
    t_posing                 r_lp [K_SQ_IN:K_P];
    logic [SQ_W-1:0]         sq_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_den   <= r3_d2 * r3_s;
            // lanes: a_vx, a_vy use b's radius; b_vx, b_vy use a's
            r4_vp[0] <= VP_W'(r3_dot * r3_pi.pbx);
            r4_vp[1] <= VP_W'(r3_dot * r3_pi.pby);
            r4_vp[2] <= VP_W'(r3_dot * r3_pi.pax);
            r4_vp[3] <= VP_W'(r3_dot * r3_pi.pay);
            r_lp[K_SQ_IN] <= r3_pi;
            for (int i = K_SQ_IN + 1; i <= K_P; i++) begin
                r_lp[i] <= r_lp[i-1];
            end
        end
    end

    cpcr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ({r3_d2, SQ_SH'(0)}),
        .o_root (sq_d)
    );

    // ---------------------------------------------------------------
    // Stage 5: round-to-nearest setup for velocity divides:
    // q = (2|num| + den) / (2 den), num = 2 * vp
    // ---------------------------------------------------------------
    logic [DIV_NW-1:0] r5_vn [NLANE];
    logic [DIV_DW-1:0] r5_vd;
    logic [NLANE-1:0]  n_vsg;
    logic [VP_W-1:0]   vmag [NLANE];

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            n_vsg[j] = r4_vp[j][VP_W-1];
            vmag[j]  = n_vsg[j] ? VP_W'(-r4_vp[j]) : VP_W'(r4_vp[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NLANE; j++) begin
                r5_vn[j] <= DIV_NW'({vmag[j], 2'b00}) + DIV_NW'(r4_den);
            end
            r5_vd <= {r4_den, 1'b0};
        end
    end

    // ---------------------------------------------------------------
    // Stage 25..27: position numerators over the distance D
    // ---------------------------------------------------------------
    logic signed [MX_W-1:0]  r25_mx, r25_my;
    logic [SQ_W-1:0]         r25_d, r26_d;
    logic signed [PN_W-1:0]  r26_n [NLANE];
    logic [NLANE-1:0]        n_psg;
    logic [DIV_NW-1:0]       r27_pn [NLANE];
    logic [DIV_DW-1:0]       r27_pd;
    logic signed [SQ_W:0]    d_s;
    logic [PN_W-1:0]         pmag [NLANE];

    assign d_s = $signed({1'b0, sq_d});

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            n_psg[j] = r26_n[j][PN_W-1];
            pmag[j]  = n_psg[j] ? PN_W'(-r26_n[j]) : PN_W'(r26_n[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r25_mx <= MX_W'(r_lp[K_SQ_OUT].sumx * d_s);
            r25_my <= MX_W'(r_lp[K_SQ_OUT].sumy * d_s);
            r25_d  <= sq_d;
            r26_n[0] <= PN_W'(r25_mx) + (PN_W'(r_lp[K_P].pax) <<< PSH);
            r26_n[1] <= PN_W'(r25_my) + (PN_W'(r_lp[K_P].pay) <<< PSH);
            r26_n[2] <= PN_W'(r25_mx) - (PN_W'(r_lp[K_P].pbx) <<< PSH);
            r26_n[3] <= PN_W'(r25_my) - (PN_W'(r_lp[K_P].pby) <<< PSH);
            r26_d  <= r25_d;
            for (int j = 0; j < NLANE; j++) begin
                r27_pn[j] <= DIV_NW'({pmag[j], 1'b0}) + DIV_NW'({r26_d, 1'b0});
            end
            r27_pd <= DIV_DW'({r26_d, 2'b00});
        end
    end

    // ---------------------------------------------------------------
    // Dividers
    // ---------------------------------------------------------------
    logic [DIV_QW-1:0]             vq [NLANE];
    logic [DIV_QW-1:0]             pq [NLANE];
    logic [NLANE-1:0][DIV_QW-1:0]  vq_p;

    for (genvar j = 0; j < NLANE; j++) begin : g_div
        cpcr_div u_vdiv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r5_vn[j]),
            .i_den (r5_vd),
            .o_quo (vq[j])
        );
        cpcr_div u_pdiv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r27_pn[j]),
            .i_den (r27_pd),
            .o_quo (pq[j])
        );
    end

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            vq_p[j] = vq[j];
        end
    end

    // sign / velocity-quotient line
    t_vel r_lv [K_VEL:K_END];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lv[K_VEL] <= '{vsg: n_vsg, psg: '0, vq: '0};
            for (int i = K_VEL + 1; i <= K_END; i++) begin
                r_lv[i].vsg <= r_lv[i-1].vsg;
                r_lv[i].psg <= (i == K_PSG) ? n_psg : r_lv[i-1].psg;
                r_lv[i].vq  <= (i == K_VQ) ? vq_p : r_lv[i-1].vq;
            end
        end
    end

    // ---------------------------------------------------------------
    // Final: signs, velocity update, saturation, pass-through select
    // ---------------------------------------------------------------
    t_result                n_res;
    t_side                  sd;
    t_vel                   lv;
    logic signed [QS_W-1:0] sv [NLANE];
    logic signed [QS_W-1:0] sp [NLANE];
    logic                   w;

    assign sd = r_la[K_END];
    assign lv = r_lv[K_END];
    assign w  = r_vld[K_END] && en;

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            sv[j] = apply_sign(lv.vsg[j], lv.vq[j]);
            sp[j] = apply_sign(lv.psg[j], pq[j]);
        end
        n_res.hit = sd.hit;
        if (sd.hit && !sd.zero) begin
            n_res.nax  = sat16(sp[0]);
            n_res.nay  = sat16(sp[1]);
            n_res.nbx  = sat16(sp[2]);
            n_res.nby  = sat16(sp[3]);
            n_res.navx = sat16(QS_W'(sd.avx) - sv[0]);
            n_res.navy = sat16(QS_W'(sd.avy) - sv[1]);
            n_res.nbvx = sat16(QS_W'(sd.bvx) + sv[2]);
            n_res.nbvy = sat16(QS_W'(sd.bvy) + sv[3]);
        end else begin
            n_res.nax  = sd.ax;
            n_res.nay  = sd.ay;
            n_res.nbx  = sd.bx;
            n_res.nby  = sd.by;
            n_res.navx = sd.avx;
            n_res.navy = sd.avy;
            n_res.nbvx = sd.bvx;
            n_res.nbvy = sd.bvy;
        end
    end

    // ---------------------------------------------------------------
    // Output register + skid entry
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!i_stall) begin
                r_sv <= 1'b0;          // skid moves up, output stays full
            end
        end else if (!r_ov || !i_stall) begin
            r_ov <= w;
        end else if (w) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!i_stall) begin
                r_o <= r_s;
            end
        end else if (!r_ov || !i_stall) begin
            if (w) begin
                r_o <= n_res;
            end
        end else if (w) begin
            r_s <= n_res;
        end
    end

    assign o_valid    = r_ov;
    assign o_hit      = r_o.hit;
    assign o_new_a_x  = r_o.nax;
    assign o_new_a_y  = r_o.nay;
    assign o_new_a_vx = r_o.navx;
    assign o_new_a_vy = r_o.navy;
    assign o_new_b_x  = r_o.nbx;
    assign o_new_b_y  = r_o.nby;
    assign o_new_b_vx = r_o.nbvx;
    assign o_new_b_vy = r_o.nbvy;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "circle_pair_collision_resolver_core_macros.svh"

    // skid fills only behind a held output beat
    `CPCR_ASSERT(a_skid_behind_out, !r_sv || r_ov, "skid full with output register empty")
    // a stalled output beat is never dropped
    `CPCR_ASSERT_NEXT(a_out_held, r_ov && i_stall, r_ov, "stalled output beat lost")
    // full skid freezes the pipeline
    `CPCR_ASSERT_NEXT(a_pipe_frozen, r_sv, $stable(r_vld), "pipeline moved while skid full")

endmodule

`default_nettype wire

// ===== hdl/cpcr_sqrt.sv =====
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module cpcr_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cpcr_pkg::SQ_IN_W-1:0]  i_rad,
    output logic [cpcr_pkg::SQ_W-1:0]     o_root
);
    import cpcr_pkg::*;

    logic [SQ_W_EX-1:0] r_rem  [SQ_W];
    logic [SQ_W-1:0]    r_root [SQ_W];

    for (genvar g = 0; g < SQ_W; g++) begin : g_stage
        localparam int B = SQ_W - 1 - g;
        logic [SQ_W_EX-1:0] rem_in;
        logic [SQ_W-1:0]    root_in;
        logic [SQ_W_EX-1:0] trial;
        logic [SQ_W_EX-1:0] n_rem;
        logic [SQ_W-1:0]    n_root;

        if (g == 0) begin : g_first
            assign rem_in  = SQ_W_EX'(i_rad);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        always_comb begin
            // (root + 2^B)^2 - root^2
            trial  = (SQ_W_EX'(root_in) << (B + 1)) + (SQ_W_EX'(1) << (2 * B));
            n_rem  = rem_in;
            n_root = root_in;
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = root_in | (SQ_W'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_root = r_root[SQ_W-1];

endmodule

`default_nettype wire

// ===== hdl/cpcr_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Quotient must fit DIV_QW bits.
module cpcr_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cpcr_pkg::DIV_NW-1:0]   i_num,
    input  logic [cpcr_pkg::DIV_DW-1:0]   i_den,
    output logic [cpcr_pkg::DIV_QW-1:0]   o_quo
);
    import cpcr_pkg::*;

    logic [DIV_RW-1:0] r_rem [DIV_QW];
    logic [DIV_DW-1:0] r_den [DIV_QW];
    logic [DIV_QW-1:0] r_quo [DIV_QW];

    for (genvar g = 0; g < DIV_QW; g++) begin : g_stage
        localparam int B = DIV_QW - 1 - g;
        logic [DIV_RW-1:0] rem_in;
        logic [DIV_DW-1:0] den_in;
        logic [DIV_QW-1:0] quo_in;
        logic [DIV_RW-1:0] shifted;
        logic [DIV_RW-1:0] n_rem;
        logic [DIV_QW-1:0] n_quo;

        if (g == 0) begin : g_first
            assign rem_in = DIV_RW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
        end

        always_comb begin
            shifted = DIV_RW'(den_in) << B;
            n_rem   = rem_in;
            n_quo   = quo_in;
            if (rem_in >= shifted) begin
                n_rem = rem_in - shifted;
                n_quo = quo_in | (DIV_QW'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
                r_quo[g] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[DIV_QW-1];

endmodule

`default_nettype wire
